### hdl/wavetable_synth_voice_unit_macros.svh
// assertion macros for the wavetable synth voice checker
// no dependencies
`ifndef WAVETABLE_SYNTH_VOICE_UNIT_MACROS_SVH
`define WAVETABLE_SYNTH_VOICE_UNIT_MACROS_SVH

// same-cycle implication, quiet during reset
`define WSV_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, quiet during reset
`define WSV_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/wsv_pkg.sv
// shared types and constants of the wavetable synth voice
// no dependencies
package wsv_pkg;

   localparam int TABLE_DEPTH = 2048;
   localparam int RAMP_TICKS  = 48;
   localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
   localparam int INDEX_BITS  = $clog2(TABLE_DEPTH + 1) - 1;
   localparam int LEFT_BITS   = $clog2(RAMP_TICKS + 1);
   localparam int RECIP_SHIFT = 24;
   localparam logic [31:0] RAMP_RECIP =
      32'(((64'd1 << RECIP_SHIFT) + 64'(RAMP_TICKS) - 64'd1) / 64'(RAMP_TICKS));
   localparam logic [31:0] HP_COEF = 32'h7C7E5B51;
   localparam int LFSR_BITS = 23;

   typedef enum logic [1:0] {
      OP_TICK      = 2'd0,
      OP_WR_FIRST  = 2'd1,
      OP_WR_SECOND = 2'd2,
      OP_NONE      = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      CSR_PHASE_STEP = 3'd0,
      CSR_PWM_OFFSET = 3'd1,
      CSR_NOISE_RATE = 3'd2,
      CSR_TABLE_MIX  = 3'd3,
      CSR_NOISE_SEL  = 3'd4,
      CSR_PWM_EN     = 3'd5,
      CSR_HP_EN      = 3'd6,
      CSR_NOISE_SEED = 3'd7
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_START,
      ST_RD,
      ST_MA,
      ST_MB,
      ST_MX,
      ST_ACC,
      ST_RMUL,
      ST_RUPD,
      ST_VMUL,
      ST_VTAKE,
      ST_HUPD,
      ST_OUT
   } state_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_DIFF_A,
      MUL_DIFF_B,
      MUL_MIX,
      MUL_RAMP,
      MUL_VOL,
      MUL_HP
   } mul_sel_type;

   typedef struct packed {
      logic        tick_go;
      logic        wr_go;
      logic        start_go;
      mul_sel_type mul_sel;
      logic        ia_ld;
      logic        osc_ld;
      logic        ramp_upd;
      logic        res_take;
      logic        hp_upd;
      logic        out_go;
   } cmd_type;

   typedef struct packed {
      logic noise_sel;
      logic pwm_en;
      logic hp_en;
      logic pass;
      logic out_free;
   } status_type;

endpackage

### hdl/wsv_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module wsv_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/wsv_datapath.sv
// datapath of the synth voice: tables, oscillator, noise, ramp, highpass
// depends on wsv_pkg and wsv_ram
module wsv_datapath (
   input  logic                 clock,
   input  logic                 reset,
   input  wsv_pkg::cmd_type     cmd,
   output wsv_pkg::status_type  status,
   input  wsv_pkg::op_type      req_op,
   input  logic [10:0]          req_table_index,
   input  logic [31:0]          req_table_word,
   input  logic [15:0]          req_volume,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [2:0]           csr_index,
   input  logic [31:0]          csr_data,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [31:0]          rsp_tdata
);

   localparam int AB = wsv_pkg::ADDR_BITS;
   localparam int IB = wsv_pkg::INDEX_BITS;
   localparam int LB = wsv_pkg::LEFT_BITS;

   // config
   logic [31:0] phase_step_ff, pwm_offset_ff, noise_rate_ff;
   logic [7:0]  mix_ff;
   logic        noise_sel_ff, pwm_en_ff, hp_en_ff;

   // voice state
   logic [31:0]                  osc_phase_ff, noise_phase_ff;
   logic [wsv_pkg::LFSR_BITS-1:0] lfsr_ff;
   logic signed [16:0]           ramp_cur_ff;
   logic [15:0]                  ramp_target_ff;
   logic [LB-1:0]                ramp_left_ff;
   logic signed [17:0]           ramp_step_ff;
   logic signed [31:0]           hp_in_ff, hp_out_ff;

   // work registers
   logic [15:0]        vol_ff;
   logic               pass_ff;
   logic signed [64:0] prod_ff;
   logic signed [24:0] ia_ff;
   logic signed [33:0] osc1_ff, acc_ff;
   logic signed [31:0] res_ff;
   logic               out_valid_ff;
   logic [31:0]        out_data_ff;

   wsv_pkg::csr_index_type csr_sel;
   logic [31:0]    rd_phase;
   logic [IB-1:0]  idx;
   logic [7:0]     frac;
   logic [AB-1:0]  rd_addr, wr_addr;
   logic           wr_ok;
   logic [31:0]    first_rd, second_rd;
   logic signed [15:0] a0, a1, b0, b1;
   logic signed [16:0] da, db;
   logic signed [24:0] base_a, base_b, ib;
   logic signed [25:0] dmix;
   logic signed [33:0] osc;
   logic signed [32:0] mul_a;
   logic signed [31:0] mul_b;
   logic [32:0]        noise_sum;
   logic               fb;
   logic [wsv_pkg::LFSR_BITS-1:0] lfsr_shift, lfsr_nx;
   logic signed [33:0] noise_val;
   logic signed [17:0] rdiff, qs, step_calc, step_use;
   logic [16:0]        dmag, q;
   logic               differ;
   logic [LB-1:0]      left_use;
   logic signed [32:0] ay;
   logic signed [34:0] y_wide;
   logic signed [31:0] y_sat;
   logic               out_free;

   assign csr_sel   = wsv_pkg::csr_index_type'(csr_index);
   assign csr_ready = 1'b1;

   // table access
   assign rd_phase = pass_ff ? osc_phase_ff + pwm_offset_ff : osc_phase_ff;
   assign idx      = rd_phase[31 -: IB];
   assign frac     = rd_phase[31-IB -: 8];
   assign rd_addr  = (32'(idx) < wsv_pkg::TABLE_DEPTH) ? AB'(idx) : '0;
   assign wr_ok    = 32'(req_table_index) < wsv_pkg::TABLE_DEPTH;
   assign wr_addr  = AB'(req_table_index);

   wsv_ram #(.WIDTH(32), .DEPTH(wsv_pkg::TABLE_DEPTH)) u_table_first (
      .clock   (clock),
      .wr_en   (cmd.wr_go && wr_ok && req_op == wsv_pkg::OP_WR_FIRST),
      .wr_addr (wr_addr),
      .wr_data (req_table_word),
      .rd_addr (rd_addr),
      .rd_data (first_rd)
   );

   wsv_ram #(.WIDTH(32), .DEPTH(wsv_pkg::TABLE_DEPTH)) u_table_second (
      .clock   (clock),
      .wr_en   (cmd.wr_go && wr_ok && req_op == wsv_pkg::OP_WR_SECOND),
      .wr_addr (wr_addr),
      .wr_data (req_table_word),
      .rd_addr (rd_addr),
      .rd_data (second_rd)
   );

   // interpolation: 255*s0 + f*(s1-s0), then 255*ia + mix*(ib-ia)
   assign a0     = first_rd[15:0];
   assign a1     = first_rd[31:16];
   assign b0     = second_rd[15:0];
   assign b1     = second_rd[31:16];
   assign da     = 17'(a1) - 17'(a0);
   assign db     = 17'(b1) - 17'(b0);
   assign base_a = (25'(a0) <<< 8) - 25'(a0);
   assign base_b = (25'(b0) <<< 8) - 25'(b0);
   assign ib     = base_b + $signed(prod_ff[24:0]);
   assign dmix   = 26'(ib) - 26'(ia_ff);
   assign osc    = (34'(ia_ff) <<< 8) - 34'(ia_ff) + $signed(prod_ff[33:0]);

   // noise
   assign noise_sum  = {1'b0, noise_phase_ff} + {1'b0, noise_rate_ff};
   assign fb         = lfsr_ff[22] ^ lfsr_ff[17];
   assign lfsr_shift = {lfsr_ff[21:0], fb};
   always_comb begin
      lfsr_nx = lfsr_ff;
      if (noise_sum[32]) begin
         lfsr_nx = (lfsr_shift == '0) ? wsv_pkg::LFSR_BITS'(1) : lfsr_shift;
      end
   end
   assign noise_val = 34'($signed({~lfsr_nx[22], lfsr_nx[21:7], 16'h0000}));

   // ramp step, truncated toward zero
   assign rdiff     = $signed({2'b00, vol_ff}) - 18'(ramp_cur_ff);
   assign dmag      = rdiff[17] ? 17'(-rdiff) : 17'(rdiff);
   assign q         = prod_ff[wsv_pkg::RECIP_SHIFT+16 : wsv_pkg::RECIP_SHIFT];
   assign qs        = $signed({1'b0, q});
   assign step_calc = rdiff[17] ? -qs : qs;
   assign differ    = ramp_target_ff != vol_ff;
   assign step_use  = differ ? step_calc : ramp_step_ff;
   assign left_use  = differ ? LB'(wsv_pkg::RAMP_TICKS) : ramp_left_ff;

   // highpass
   assign ay     = $signed(prod_ff[63:31]);
   assign y_wide = 35'(res_ff) - 35'(hp_in_ff) + 35'(ay);
   always_comb begin
      if (y_wide[34:31] == 4'b0000 || y_wide[34:31] == 4'b1111) begin
         y_sat = y_wide[31:0];
      end else if (y_wide[34]) begin
         y_sat = 32'sh80000000;
      end else begin
         y_sat = 32'sh7FFFFFFF;
      end
   end

   // shared multiplier operands
   always_comb begin
      case (cmd.mul_sel)
         wsv_pkg::MUL_DIFF_A: begin
            mul_a = 33'(da);
            mul_b = $signed(32'(frac));
         end
         wsv_pkg::MUL_DIFF_B: begin
            mul_a = 33'(db);
            mul_b = $signed(32'(frac));
         end
         wsv_pkg::MUL_MIX: begin
            mul_a = 33'(dmix);
            mul_b = $signed(32'(mix_ff));
         end
         wsv_pkg::MUL_RAMP: begin
            mul_a = $signed(33'(dmag));
            mul_b = $signed(wsv_pkg::RAMP_RECIP);
         end
         wsv_pkg::MUL_VOL: begin
            mul_a = $signed(acc_ff[33:1]);
            mul_b = 32'(ramp_cur_ff);
         end
         wsv_pkg::MUL_HP: begin
            mul_a = $signed(33'(wsv_pkg::HP_COEF));
            mul_b = hp_out_ff;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign out_free = !out_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (cmd.tick_go) begin
         vol_ff <= req_volume;
      end
      if (cmd.start_go) begin
         pass_ff <= noise_sel_ff;
         if (noise_sel_ff) begin
            osc1_ff <= noise_val;
            acc_ff  <= noise_val;
         end
      end
      if (cmd.ia_ld) begin
         ia_ff <= base_a + $signed(prod_ff[24:0]);
      end
      if (cmd.osc_ld) begin
         if (!pass_ff) begin
            osc1_ff <= osc;
            acc_ff  <= osc;
            pass_ff <= 1'b1;
         end else begin
            acc_ff <= osc - osc1_ff;
         end
      end
      if (cmd.res_take) begin
         res_ff <= prod_ff[47:16];
      end
      if (cmd.hp_upd) begin
         res_ff <= y_sat;
      end
      if (cmd.out_go && out_free) begin
         out_data_ff <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_step_ff  <= '0;
         pwm_offset_ff  <= '0;
         noise_rate_ff  <= '0;
         mix_ff         <= '0;
         noise_sel_ff   <= 1'b0;
         pwm_en_ff      <= 1'b0;
         hp_en_ff       <= 1'b0;
         osc_phase_ff   <= '0;
         noise_phase_ff <= '0;
         lfsr_ff        <= wsv_pkg::LFSR_BITS'(1);
         ramp_cur_ff    <= '0;
         ramp_target_ff <= '0;
         ramp_left_ff   <= '0;
         ramp_step_ff   <= '0;
         hp_in_ff       <= '0;
         hp_out_ff      <= '0;
         out_valid_ff   <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_sel)
               wsv_pkg::CSR_PHASE_STEP: phase_step_ff <= csr_data;
               wsv_pkg::CSR_PWM_OFFSET: pwm_offset_ff <= csr_data;
               wsv_pkg::CSR_NOISE_RATE: noise_rate_ff <= csr_data;
               wsv_pkg::CSR_TABLE_MIX:  mix_ff        <= csr_data[7:0];
               wsv_pkg::CSR_NOISE_SEL:  noise_sel_ff  <= csr_data[0];
               wsv_pkg::CSR_PWM_EN:     pwm_en_ff     <= csr_data[0];
               wsv_pkg::CSR_HP_EN:      hp_en_ff      <= csr_data[0];
               wsv_pkg::CSR_NOISE_SEED: begin
                  lfsr_ff <= (csr_data[22:0] == '0) ? wsv_pkg::LFSR_BITS'(1)
                                                    : csr_data[22:0];
               end
               default: ;
            endcase
         end
         if (cmd.tick_go) begin
            osc_phase_ff <= osc_phase_ff + phase_step_ff;
         end
         if (cmd.start_go && noise_sel_ff) begin
            noise_phase_ff <= noise_sum[31:0];
            lfsr_ff        <= lfsr_nx;
         end
         if (cmd.ramp_upd) begin
            ramp_target_ff <= vol_ff;
            ramp_step_ff   <= step_use;
            if (left_use != '0) begin
               ramp_cur_ff  <= 17'(18'(ramp_cur_ff) + step_use);
               ramp_left_ff <= left_use - LB'(1);
            end else begin
               ramp_cur_ff  <= $signed({1'b0, vol_ff});
               ramp_left_ff <= '0;
            end
         end
         if (cmd.hp_upd) begin
            hp_in_ff  <= res_ff;
            hp_out_ff <= y_sat;
         end
         if (cmd.out_go && out_free) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign status.noise_sel = noise_sel_ff;
   assign status.pwm_en    = pwm_en_ff;
   assign status.hp_en     = hp_en_ff;
   assign status.pass      = pass_ff;
   assign status.out_free  = out_free;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

### hdl/wsv_ctrl.sv
// controller of the synth voice: sequences the shared multiplier steps
// depends on wsv_pkg
module wsv_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  wsv_pkg::op_type     req_op,
   input  wsv_pkg::status_type status,
   output wsv_pkg::cmd_type    cmd
);

   wsv_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= wsv_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wsv_pkg::ST_IDLE: begin
            if (req_tvalid && req_op == wsv_pkg::OP_TICK) begin
               state_in = wsv_pkg::ST_START;
            end
         end
         wsv_pkg::ST_START: begin
            if (status.noise_sel && !status.pwm_en) begin
               state_in = wsv_pkg::ST_RMUL;
            end else begin
               state_in = wsv_pkg::ST_RD;
            end
         end
         wsv_pkg::ST_RD:  state_in = wsv_pkg::ST_MA;
         wsv_pkg::ST_MA:  state_in = wsv_pkg::ST_MB;
         wsv_pkg::ST_MB:  state_in = wsv_pkg::ST_MX;
         wsv_pkg::ST_MX:  state_in = wsv_pkg::ST_ACC;
         wsv_pkg::ST_ACC: begin
            if (!status.pass && status.pwm_en) begin
               state_in = wsv_pkg::ST_RD;
            end else begin
               state_in = wsv_pkg::ST_RMUL;
            end
         end
         wsv_pkg::ST_RMUL:  state_in = wsv_pkg::ST_RUPD;
         wsv_pkg::ST_RUPD:  state_in = wsv_pkg::ST_VMUL;
         wsv_pkg::ST_VMUL:  state_in = wsv_pkg::ST_VTAKE;
         wsv_pkg::ST_VTAKE: begin
            state_in = status.hp_en ? wsv_pkg::ST_HUPD : wsv_pkg::ST_OUT;
         end
         wsv_pkg::ST_HUPD: state_in = wsv_pkg::ST_OUT;
         wsv_pkg::ST_OUT: begin
            if (status.out_free) begin
               state_in = wsv_pkg::ST_IDLE;
            end
         end
         default: state_in = wsv_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         wsv_pkg::ST_IDLE: begin
            req_tready  = 1'b1;
            cmd.tick_go = req_tvalid && req_op == wsv_pkg::OP_TICK;
            cmd.wr_go   = req_tvalid && (req_op == wsv_pkg::OP_WR_FIRST
                                         || req_op == wsv_pkg::OP_WR_SECOND);
         end
         wsv_pkg::ST_START: cmd.start_go = 1'b1;
         wsv_pkg::ST_MA:    cmd.mul_sel  = wsv_pkg::MUL_DIFF_A;
         wsv_pkg::ST_MB: begin
            cmd.mul_sel = wsv_pkg::MUL_DIFF_B;
            cmd.ia_ld   = 1'b1;
         end
         wsv_pkg::ST_MX:    cmd.mul_sel  = wsv_pkg::MUL_MIX;
         wsv_pkg::ST_ACC:   cmd.osc_ld   = 1'b1;
         wsv_pkg::ST_RMUL:  cmd.mul_sel  = wsv_pkg::MUL_RAMP;
         wsv_pkg::ST_RUPD:  cmd.ramp_upd = 1'b1;
         wsv_pkg::ST_VMUL:  cmd.mul_sel  = wsv_pkg::MUL_VOL;
         wsv_pkg::ST_VTAKE: begin
            cmd.res_take = 1'b1;
            cmd.mul_sel  = wsv_pkg::MUL_HP;
         end
         wsv_pkg::ST_HUPD:  cmd.hp_upd   = 1'b1;
         wsv_pkg::ST_OUT:   cmd.out_go   = 1'b1;
         default: ;
      endcase
   end

endmodule

### hdl/wavetable_synth_voice_unit.sv
// wavetable synth voice: a table write item leaves the controller idle; a tick item
// runs from accept to result through the steps of the one shared 33x32 multiplier
// (3 steps per oscillator read, one each for ramp step, volume and highpass)
// one item at a time; the result register lets the next item in while it waits
// reset: synchronous, clears control state, config and voice state registers, lfsr loads 1
module wavetable_synth_voice_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // op, table_index, table_word, volume, zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // sample
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);

   wsv_pkg::cmd_type    cmd;
   wsv_pkg::status_type status;
   wsv_pkg::op_type     req_op;

   assign req_op = wsv_pkg::op_type'(req_tdata[1:0]);

   wsv_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_op),
      .status     (status),
      .cmd        (cmd)
   );

   wsv_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_op          (req_op),
      .req_table_index (req_tdata[12:2]),
      .req_table_word  (req_tdata[44:13]),
      .req_volume      (req_tdata[60:45]),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata)
   );

endmodule

### hdl/wsv_checker.sv
// port-level checks of the synth voice, bound to the top level
// depends on wsv_pkg and wavetable_synth_voice_unit_macros.svh
`include "wavetable_synth_voice_unit_macros.svh"

module wsv_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [63:0] req_tdata,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata
);

   logic tick_acc, wr_acc, rsp_wait;

   assign tick_acc = req_tvalid && req_tready && req_tdata[1:0] == wsv_pkg::OP_TICK;
   assign wr_acc   = req_tvalid && req_tready
                     && (req_tdata[1:0] == wsv_pkg::OP_WR_FIRST
                         || req_tdata[1:0] == wsv_pkg::OP_WR_SECOND);
   assign rsp_wait = rsp_tvalid && !rsp_tready;

   `WSV_ASSERT_NEXT(a_rsp_hold, rsp_wait, rsp_tvalid && $stable(rsp_tdata), "result changed")
   `WSV_ASSERT_NEXT(a_tick_busy, tick_acc, !req_tready, "input taken right after a tick item")
   `WSV_ASSERT_NEXT(a_wr_free, wr_acc, req_tready, "table write item stalled the input")
   `WSV_ASSERT_NOW(a_rsp_after_work, $rose(rsp_tvalid), $past(!req_tready), "result while idle")

endmodule

bind wavetable_synth_voice_unit wsv_checker u_wsv_checker (.*);

### test/testbench.sv
// self-checking bench for wavetable_synth_voice_unit: random table writes,
// ticks and register settings, sample predicted per tick and checked in order
// depends on wsv_pkg and the voice unit rtl
module testbench;

   localparam int LIMIT = 3000000;
   localparam int SETTLE = 40;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [31:0] rsp_tdata;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [31:0] csr_data = '0;

   wavetable_synth_voice_unit DUT (.*);

   logic [63:0] pending[$];
   logic [31:0] samples_due[$];
   int          errors = 0;
   int          cycles = 0;
   int          send_gap = 0;
   int          recv_gap = 0;
   int          hold_left = 0;
   logic        hold_go = 0;
   logic        hold_seen = 0;
   logic        calm = 0;

   // predicted voice state
   logic [31:0] k_step, k_pwm, k_nrate;
   logic [7:0]  k_mix;
   logic        k_nsel, k_pwmen, k_hpen;
   logic [31:0] osc_ph, noise_ph;
   logic [22:0] lfsr;
   int          ramp_cur, ramp_stp, hp_in, hp_out;
   logic [15:0] ramp_tgt;
   int          ramp_left;
   logic [31:0] wave_a[wsv_pkg::TABLE_DEPTH];
   logic [31:0] wave_b[wsv_pkg::TABLE_DEPTH];

   initial forever #2 clock = ~clock;

   function automatic logic [63:0] pack_item(wsv_pkg::op_type op, logic [10:0] idx,
                                             logic [31:0] word, logic [15:0] vol);
      return {3'b0, vol, word, idx, op};
   endfunction

   function automatic longint wave_at(logic [31:0] ph);
      logic [31:0] a, b;
      longint f, wa, wb;
      a = wave_a[ph[31:21]];
      b = wave_b[ph[31:21]];
      f = longint'(ph[20:13]);
      wa = 255 - longint'(k_mix);
      wb = longint'(k_mix);
      return longint'($signed(a[15:0])) * (255 - f) * wa
           + longint'($signed(a[31:16])) * f * wa
           + longint'($signed(b[15:0])) * (255 - f) * wb
           + longint'($signed(b[31:16])) * f * wb;
   endfunction

   task automatic voice_tick(logic [15:0] vol);
      longint first, acc, ay, y;
      logic [31:0] np;
      logic [31:0] s;
      osc_ph = osc_ph + k_step;
      if (k_nsel) begin
         np = noise_ph + k_nrate;
         if (np < noise_ph) begin
            lfsr = {lfsr[21:0], lfsr[22] ^ lfsr[17]};
            if (lfsr == 0) lfsr = 1;
         end
         noise_ph = np;
         first = (longint'(lfsr[22:7]) - 32768) * 65536;
      end else begin
         first = wave_at(osc_ph);
      end
      acc = first;
      if (k_pwmen) acc = wave_at(osc_ph + k_pwm) - first;
      acc = acc >>> 1;
      if (ramp_tgt != vol) begin
         ramp_tgt = vol;
         ramp_left = wsv_pkg::RAMP_TICKS;
         ramp_stp = (int'(vol) - ramp_cur) / wsv_pkg::RAMP_TICKS;
      end
      if (ramp_left > 0) begin
         ramp_cur = ramp_cur + ramp_stp;
         ramp_left--;
      end else begin
         ramp_cur = int'(ramp_tgt);
      end
      acc = (acc * longint'(ramp_cur)) >>> 16;
      s = acc[31:0];
      if (k_hpen) begin
         ay = (longint'(wsv_pkg::HP_COEF) * longint'(hp_out)) >>> 31;
         y = longint'($signed(s)) - longint'(hp_in) + ay;
         if (y > 64'sd2147483647) y = 64'sd2147483647;
         if (y < -64'sd2147483648) y = -64'sd2147483648;
         hp_in = $signed(s);
         hp_out = int'(y);
         s = y[31:0];
      end
      samples_due.push_back(s);
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_tvalid <= 0;
         end else if (pending.size() > 0) begin
            req_tdata <= pending.pop_front();
            req_tvalid <= 1;
            if (!calm && $urandom_range(0, 5) == 0) send_gap <= $urandom_range(1, 7);
         end else begin
            req_tvalid <= 0;
         end
      end
   end

   // receiver
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_go && !hold_seen) begin
         hold_seen <= 1;
         hold_left <= 400;
         rsp_tready <= 0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 0;
      end else if (recv_gap > 0) begin
         recv_gap <= recv_gap - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= 1;
         if (!calm && $urandom_range(0, 5) == 0) recv_gap <= $urandom_range(1, 7);
      end
   end

   // monitor and predictor
   always @(posedge clock) begin
      logic [31:0] want;
      if (reset) begin
         k_step = 0; k_pwm = 0; k_nrate = 0; k_mix = 0;
         k_nsel = 0; k_pwmen = 0; k_hpen = 0;
         osc_ph = 0; noise_ph = 0; lfsr = 1;
         ramp_cur = 0; ramp_stp = 0; hp_in = 0; hp_out = 0;
         ramp_tgt = 0; ramp_left = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (wsv_pkg::csr_index_type'(csr_index))
               wsv_pkg::CSR_PHASE_STEP: k_step = csr_data;
               wsv_pkg::CSR_PWM_OFFSET: k_pwm = csr_data;
               wsv_pkg::CSR_NOISE_RATE: k_nrate = csr_data;
               wsv_pkg::CSR_TABLE_MIX:  k_mix = csr_data[7:0];
               wsv_pkg::CSR_NOISE_SEL:  k_nsel = csr_data[0];
               wsv_pkg::CSR_PWM_EN:     k_pwmen = csr_data[0];
               wsv_pkg::CSR_HP_EN:      k_hpen = csr_data[0];
               wsv_pkg::CSR_NOISE_SEED:
                  lfsr = (csr_data[22:0] != 0) ? csr_data[22:0] : 23'd1;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            case (wsv_pkg::op_type'(req_tdata[1:0]))
               wsv_pkg::OP_TICK:      voice_tick(req_tdata[60:45]);
               wsv_pkg::OP_WR_FIRST:  wave_a[req_tdata[12:2]] = req_tdata[44:13];
               wsv_pkg::OP_WR_SECOND: wave_b[req_tdata[12:2]] = req_tdata[44:13];
               default: ;
            endcase
         end
         if (rsp_tvalid && rsp_tready) begin
            if (samples_due.size() == 0) begin
               errors++;
               if (errors <= 10) $display("unexpected sample %h", rsp_tdata);
            end else begin
               want = samples_due.pop_front();
               if (want !== rsp_tdata) begin
                  errors++;
                  if (errors <= 10)
                     $display("sample mismatch: expected %h actual %h", want, rsp_tdata);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("testbench: FAIL");
         $finish;
      end
   end

   task automatic reg_write(wsv_pkg::csr_index_type idx, logic [31:0] data);
      csr_index <= idx;
      csr_data <= data;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic drain();
      while (pending.size() > 0 || samples_due.size() > 0 || req_tvalid) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic random_items(int count);
      logic [15:0] vol;
      int roll;
      vol = 16'($urandom);
      for (int n = 0; n < count; n++) begin
         roll = $urandom_range(0, 19);
         if ($urandom_range(0, 29) == 0) begin
            case ($urandom_range(0, 2))
               0: vol = 16'h0000;
               1: vol = 16'hFFFF;
               default: vol = 16'($urandom);
            endcase
         end
         if (roll < 14)
            pending.push_back(pack_item(wsv_pkg::OP_TICK, 11'($urandom), $urandom, vol));
         else if (roll < 16)
            pending.push_back(pack_item(wsv_pkg::OP_WR_FIRST, 11'($urandom), $urandom,
                                        16'($urandom)));
         else if (roll < 18)
            pending.push_back(pack_item(wsv_pkg::OP_WR_SECOND, 11'($urandom), $urandom,
                                        16'($urandom)));
         else begin
            pending.push_back(pack_item(wsv_pkg::OP_NONE, 11'($urandom), $urandom,
                                        16'($urandom)));
            n--;
         end
      end
   endtask

   initial begin
      logic [31:0] w;
      logic [31:0] cfg[8];
      repeat (6) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // fill both tables so no tick reads an unwritten entry
      for (int i = 0; i < wsv_pkg::TABLE_DEPTH; i++) begin
         w = (i % 17 == 0) ? 32'h7FFF8000 : (i % 19 == 0) ? 32'h80007FFF : $urandom;
         pending.push_back(pack_item(wsv_pkg::OP_WR_FIRST, 11'(i), w, 16'($urandom)));
         w = (i % 13 == 0) ? 32'hFFFFFFFF : (i % 23 == 0) ? 32'h00000000 : $urandom;
         pending.push_back(pack_item(wsv_pkg::OP_WR_SECOND, 11'(i), w, 16'($urandom)));
      end
      drain();

      // directed ticks at reset settings but for the phase step, then extremes
      reg_write(wsv_pkg::CSR_PHASE_STEP, 32'h00123456);
      csr_valid <= 0;
      drain();
      pending.push_back(pack_item(wsv_pkg::OP_TICK, 11'h7FF, 32'hFFFFFFFF, 16'hFFFF));
      pending.push_back(pack_item(wsv_pkg::OP_NONE, 11'h000, 32'h00000000, 16'h0000));
      pending.push_back(pack_item(wsv_pkg::OP_WR_FIRST, 11'h7FF, 32'h80008000, 16'h0000));
      pending.push_back(pack_item(wsv_pkg::OP_WR_SECOND, 11'h000, 32'h7FFF7FFF, 16'hFFFF));
      for (int i = 0; i < 8; i++)
         pending.push_back(pack_item(wsv_pkg::OP_TICK, 11'h000, 32'h0, 16'hFFFF));
      for (int i = 0; i < 4; i++)
         pending.push_back(pack_item(wsv_pkg::OP_TICK, 11'h000, 32'h0, 16'h0000));
      for (int i = 0; i < 4; i++)
         pending.push_back(pack_item(wsv_pkg::OP_TICK, 11'h7FF, 32'hFFFFFFFF, 16'h8000));
      drain();

      for (int p = 0; p < 9; p++) begin
         case (p)
            0: cfg = '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFF, 1, 1, 1, 32'h7FFFFF};
            1: cfg = '{32'h0, 32'h0, 32'h0, 32'h0, 0, 0, 0, 32'h0};
            2: cfg = '{32'h80000000, 32'h80000000, 32'h80000000, 32'h80, 1, 0, 1, 32'h1};
            3: cfg = '{32'h01000000, 32'h40000000, 32'h10000000, 32'hFF, 0, 1, 1, 32'h400000};
            default: cfg = '{$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, $urandom};
         endcase
         for (int r = 0; r < 8; r++) reg_write(wsv_pkg::csr_index_type'(r), cfg[r]);
         csr_valid <= 0;
         if (p == 4) hold_go <= 1;
         if (p == 8) calm <= 1;
         random_items(205);
         drain();
      end

      if (errors == 0 && samples_due.size() == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end
endmodule

### files.f
+incdir+hdl
hdl/wsv_pkg.sv
hdl/wsv_ram.sv
hdl/wsv_datapath.sv
hdl/wsv_ctrl.sv
hdl/wavetable_synth_voice_unit.sv
hdl/wsv_checker.sv
test/testbench.sv
